FILE: hw/rtl/assert_macros.svh
// assertion macros used by the rtl top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/ills_pkg.sv
// shared widths, codes and defaults of the linked list store
package ills_pkg;

  localparam int OP_W        = 3;
  localparam int POS_W       = 5;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;
  localparam int VALUE_MAX_W = 64;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

FILE: hw/rtl/ills_if.sv
// request and result channel interfaces
interface ills_in_if import ills_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [POS_W-1:0]    position;
  logic [DATA_W-1:0]   data_value;

  modport source (output valid, output op, output position, output data_value, input ready);
  modport sink   (input valid, input op, input position, input data_value, output ready);
endinterface

interface ills_out_if import ills_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   read_value;
  logic [COUNT_W-1:0]  element_count;

  modport source (output valid, output status, output read_value, output element_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input element_count,
                  output ready);
endinterface

FILE: hw/rtl/indexed_linked_list_store_top.sv
// one request at a time; a request is held from acceptance until its result is loaded
// a rejected or unknown request goes from S_DECIDE straight to S_RESP
// a walk follows k links to the position, k <= length/2, one link per S_WALK and S_WSTEP pass
// next request taken in the cycle after the result loads
// synchronous active-low reset empties the list at once; the rams need no clearing pass
`include "assert_macros.svh"

module indexed_linked_list_store_top import ills_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ills_in_if.sink  in_ch,
  ills_out_if.source out_ch
);

  // slot index and element count widths follow from the pool size
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // sequencer states, one-hot
  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DECIDE = 12'b0000_0000_0010,
    S_POP    = 12'b0000_0000_0100,
    S_WALK   = 12'b0000_0000_1000,
    S_WSTEP  = 12'b0000_0001_0000,
    S_BWAIT  = 12'b0000_0010_0000,
    S_RDWAIT = 12'b0000_0100_0000,
    S_RMWAIT = 12'b0000_1000_0000,
    S_FREE   = 12'b0001_0000_0000,
    S_LINK1  = 12'b0010_0000_0000,
    S_LINK2  = 12'b0100_0000_0000,
    S_RESP   = 12'b1000_0000_0000
  } state_t;

  // where in the list an insert or remove lands
  typedef enum logic [1:0] {
    EK_SOLE,
    EK_HEAD,
    EK_TAIL,
    EK_MID
  } edge_kind_t;

  state_t                  state_r, state_nxt;
  edge_kind_t              kind_r, kind_nxt;
  logic [OP_W-1:0]         op_r;
  logic [POS_W-1:0]        pos_r;
  logic [VALUE_WIDTH-1:0]  val_r;
  logic [SLOT_W-1:0]       head_r, head_nxt;
  logic [SLOT_W-1:0]       tail_r, tail_nxt;
  logic [CNT_W-1:0]        len_r, len_nxt;
  logic [CNT_W-1:0]        fs_r, fs_nxt;        // entries on the free stack
  logic [CNT_W-1:0]        fresh_r, fresh_nxt;  // slots never handed out so far
  logic [SLOT_W-1:0]       cur_r, cur_nxt;      // walk pointer, also the located slot
  logic [SLOT_W-1:0]       aux_r, aux_nxt;      // predecessor for a link-in
  logic [SLOT_W-1:0]       new_r, new_nxt;      // freshly allocated slot
  logic [CNT_W-1:0]        steps_r, steps_nxt;
  logic                    dir_bwd_r, dir_bwd_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;
  logic [VALUE_WIDTH-1:0]  rv_r, rv_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r;
  logic [DATA_W-1:0]       out_rv_r;
  logic [COUNT_W-1:0]      out_cnt_r;
  logic                    out_load;

  // ram ports
  logic                    val_we, fwd_we, bwd_we, free_we;
  logic [SLOT_W-1:0]       val_waddr, fwd_waddr, bwd_waddr, free_waddr;
  logic [VALUE_WIDTH-1:0]  val_wdata, val_rdata;
  logic [SLOT_W-1:0]       fwd_wdata, bwd_wdata, free_wdata;
  logic [SLOT_W-1:0]       fwd_rdata, bwd_rdata, free_rdata;
  logic [CNT_W-1:0]        fs_dec;

  // comparison helpers at one common width, widened value copies and the accept strobe
  logic [CMP_W-1:0]        pos_x, len_x, cap_x;
  logic [VALUE_MAX_W-1:0]  data_wide, rv_wide;
  logic                    in_acc;

  assign pos_x  = CMP_W'(pos_r);
  assign len_x  = CMP_W'(len_r);
  assign cap_x  = CMP_W'(CAPACITY);
  assign fs_dec = fs_r - CNT_W'(1);

  assign data_wide = VALUE_MAX_W'(in_ch.data_value);
  assign rv_wide   = VALUE_MAX_W'(rv_r);

  // requests are taken only while the sequencer rests; a waiting result does not block
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // value, forward link, backward link and free stack storage
  ills_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(cur_r), .rdata(val_rdata)
  );

  ills_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_fwd_ram (
    .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
    .raddr(cur_r), .rdata(fwd_rdata)
  );

  ills_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_bwd_ram (
    .clk(clk), .we(bwd_we), .waddr(bwd_waddr), .wdata(bwd_wdata),
    .raddr(cur_r), .rdata(bwd_rdata)
  );

  // top of stack is read every cycle, so it is ready in the cycle after the decision
  ills_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(fs_dec[SLOT_W-1:0]), .rdata(free_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    len_nxt     = len_r;
    fs_nxt      = fs_r;
    fresh_nxt   = fresh_r;
    cur_nxt     = cur_r;
    aux_nxt     = aux_r;
    new_nxt     = new_r;
    steps_nxt   = steps_r;
    dir_bwd_nxt = dir_bwd_r;
    status_nxt  = status_r;
    rv_nxt      = rv_r;

    val_we     = 1'b0;
    val_waddr  = cur_r;
    val_wdata  = val_r;
    fwd_we     = 1'b0;
    fwd_waddr  = cur_r;
    fwd_wdata  = '0;
    bwd_we     = 1'b0;
    bwd_waddr  = cur_r;
    bwd_wdata  = '0;
    free_we    = 1'b0;
    free_waddr = fs_r[SLOT_W-1:0];
    free_wdata = cur_r;

    out_load = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        status_nxt = ST_DONE;
        rv_nxt     = '0;
        // walk set-up: from the head when the position lies in the first half
        if (pos_x <= (len_x >> 1)) begin
          cur_nxt     = head_r;
          dir_bwd_nxt = 1'b0;
          steps_nxt   = CNT_W'(pos_x);
        end else begin
          cur_nxt     = tail_r;
          dir_bwd_nxt = 1'b1;
          steps_nxt   = CNT_W'(len_x - pos_x - CMP_W'(1));
        end
        aux_nxt = tail_r;

        case (op_r)
          OP_APPEND, OP_INSERT: begin
            if (op_r == OP_INSERT && pos_x > len_x) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_RESP;
            end else if (len_x == cap_x) begin
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              if (len_r == '0) begin
                kind_nxt = EK_SOLE;
              end else if (op_r == OP_APPEND || pos_x == len_x) begin
                kind_nxt = EK_TAIL;
              end else if (pos_r == '0) begin
                kind_nxt = EK_HEAD;
                cur_nxt  = head_r;
              end else begin
                kind_nxt = EK_MID;
              end
              // allocation: recycled slot first, else a never-used one
              if (fs_r != '0) begin
                fs_nxt    = fs_dec;
                state_nxt = S_POP;
              end else begin
                new_nxt   = fresh_r[SLOT_W-1:0];
                fresh_nxt = fresh_r + CNT_W'(1);
                state_nxt = (kind_nxt == EK_MID) ? S_WALK : S_LINK1;
              end
            end
          end

          OP_UPDATE, OP_REMOVE, OP_READ: begin
            if (pos_x >= len_x) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_RESP;
            end else begin
              if (len_r == CNT_W'(1)) begin
                kind_nxt = EK_SOLE;
              end else if (pos_r == '0) begin
                kind_nxt = EK_HEAD;
              end else if (pos_x == len_x - CMP_W'(1)) begin
                kind_nxt = EK_TAIL;
              end else begin
                kind_nxt = EK_MID;
              end
              state_nxt = S_WALK;
            end
          end

          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      S_POP: begin
        new_nxt   = free_rdata;
        state_nxt = (kind_r == EK_MID) ? S_WALK : S_LINK1;
      end

      S_WALK: begin
        if (steps_r == '0) begin
          // cur_r is the slot at the position; its links and value are read now
          case (op_r)
            OP_UPDATE: begin
              val_we    = 1'b1;
              val_waddr = cur_r;
              state_nxt = S_RESP;
            end
            OP_READ:   state_nxt = S_RDWAIT;
            OP_REMOVE: state_nxt = S_RMWAIT;
            default:   state_nxt = S_BWAIT;
          endcase
        end else begin
          state_nxt = S_WSTEP;
        end
      end

      S_WSTEP: begin
        cur_nxt   = dir_bwd_r ? bwd_rdata : fwd_rdata;
        steps_nxt = steps_r - CNT_W'(1);
        state_nxt = S_WALK;
      end

      S_RDWAIT: begin
        rv_nxt    = val_rdata;
        state_nxt = S_RESP;
      end

      S_BWAIT: begin
        aux_nxt   = bwd_rdata;
        state_nxt = S_LINK1;
      end

      S_RMWAIT: begin
        // unlink cur_r using its forward and backward links
        case (kind_r)
          EK_SOLE: begin
            head_nxt = '0;
            tail_nxt = '0;
          end
          EK_HEAD: begin
            head_nxt  = fwd_rdata;
            bwd_we    = 1'b1;
            bwd_waddr = fwd_rdata;
            bwd_wdata = '0;
          end
          EK_TAIL: begin
            tail_nxt  = bwd_rdata;
            fwd_we    = 1'b1;
            fwd_waddr = bwd_rdata;
            fwd_wdata = '0;
          end
          default: begin
            fwd_we    = 1'b1;
            fwd_waddr = bwd_rdata;
            fwd_wdata = fwd_rdata;
            bwd_we    = 1'b1;
            bwd_waddr = fwd_rdata;
            bwd_wdata = bwd_rdata;
          end
        endcase
        state_nxt = S_FREE;
      end

      S_FREE: begin
        free_we   = 1'b1;
        fs_nxt    = fs_r + CNT_W'(1);
        len_nxt   = len_r - CNT_W'(1);
        state_nxt = S_RESP;
      end

      S_LINK1: begin
        val_we    = 1'b1;
        val_waddr = new_r;
        bwd_we    = 1'b1;
        bwd_waddr = new_r;
        fwd_we    = 1'b1;
        case (kind_r)
          EK_SOLE: begin
            fwd_waddr = new_r;
            fwd_wdata = '0;
            bwd_wdata = '0;
          end
          EK_HEAD: begin
            fwd_waddr = new_r;
            fwd_wdata = cur_r;
            bwd_wdata = '0;
          end
          default: begin
            fwd_waddr = aux_r;
            fwd_wdata = new_r;
            bwd_wdata = aux_r;
          end
        endcase
        state_nxt = S_LINK2;
      end

      S_LINK2: begin
        case (kind_r)
          EK_SOLE: begin
            head_nxt = new_r;
            tail_nxt = new_r;
          end
          EK_HEAD: begin
            bwd_we    = 1'b1;
            bwd_waddr = cur_r;
            bwd_wdata = new_r;
            head_nxt  = new_r;
          end
          EK_TAIL: begin
            fwd_we    = 1'b1;
            fwd_waddr = new_r;
            fwd_wdata = '0;
            tail_nxt  = new_r;
          end
          default: begin
            fwd_we    = 1'b1;
            fwd_waddr = new_r;
            fwd_wdata = cur_r;
            bwd_we    = 1'b1;
            bwd_waddr = cur_r;
            bwd_wdata = new_r;
          end
        endcase
        len_nxt   = len_r + CNT_W'(1);
        state_nxt = S_RESP;
      end

      S_RESP: begin
        // result register free or being emptied this cycle
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      fs_r        <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      fs_r        <= fs_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request payload and working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_ch.op;
      pos_r <= in_ch.position;
      val_r <= data_wide[VALUE_WIDTH-1:0];
    end
    kind_r    <= kind_nxt;
    cur_r     <= cur_nxt;
    aux_r     <= aux_nxt;
    new_r     <= new_nxt;
    steps_r   <= steps_nxt;
    dir_bwd_r <= dir_bwd_nxt;
    status_r  <= status_nxt;
    rv_r      <= rv_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_rv_r     <= rv_wide[DATA_W-1:0];
      out_cnt_r    <= COUNT_W'(len_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.read_value    = out_rv_r;
  assign out_ch.element_count = out_cnt_r;

  // slot accounting: every slot handed out is either in the list or on the free stack
  `ASSERT_SAME(a_slot_balance, state_r == S_IDLE,
               (CNT_W + 1)'(len_r) + (CNT_W + 1)'(fs_r) == (CNT_W + 1)'(fresh_r))
  // a walk never needs more hops than the list has links
  `ASSERT_SAME(a_walk_bound, state_r == S_WALK, steps_r < len_r)
  // a link-in only ever happens with room in the pool
  `ASSERT_SAME(a_link_room, state_r == S_LINK1, len_x < cap_x)
  // a loaded result always shows as valid on the result channel
  `ASSERT_NEXT(a_load_shows, out_load, out_valid_r)

endmodule

FILE: hw/rtl/ills_ram.sv
// generic single write port ram with registered read
module ills_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
